### rtl/core/ura_pkg.sv
// Shared types and constants of the ultrasonic range alarm.
package ura_pkg;

    localparam int DIST_BITS  = 19;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    // width * 281 >> 6 gives 1/256 cm per microsecond of echo
    localparam int DIST_MUL   = 281;
    localparam int DIST_SHIFT = 6;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALARM      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLDOFF    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAP        = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ECHO_LIMIT = 3'd6;

    typedef struct packed {
        logic [7:0]           settle_ticks;
        logic [7:0]           pulse_ticks;
        logic [DIST_BITS-1:0] near_threshold_q8;
        logic [23:0]          alarm_ticks;
        logic [23:0]          holdoff_ticks;
        logic [23:0]          gap_ticks;
        logic [15:0]          echo_limit_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        settle_ticks:      8'd2,
        pulse_ticks:       8'd10,
        near_threshold_q8: 19'd2560,
        alarm_ticks:       24'd500000,
        holdoff_ticks:     24'd1000000,
        gap_ticks:         24'd100000,
        echo_limit_ticks:  16'd65535
    };

    typedef struct packed {
        logic                 trigger_out;
        logic                 buzzer_out;
        logic                 reading_done;
        logic [DIST_BITS-1:0] distance_q8;
        logic                 object_near;
        logic                 timed_out;
    } result_t;

endpackage

### rtl/core/ura_if.sv
// Channel interfaces: echo samples in, tick results out, register writes.
interface ura_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

interface ura_out_if;
    logic                           valid;
    logic                           ready;
    logic                           trigger_out;
    logic                           buzzer_out;
    logic                           reading_done;
    logic [ura_pkg::DIST_BITS-1:0]  distance_q8;
    logic                           object_near;
    logic                           timed_out;

    modport source (output valid, output trigger_out, output buzzer_out,
                    output reading_done, output distance_q8, output object_near,
                    output timed_out, input ready);
    modport sink   (input valid, input trigger_out, input buzzer_out,
                    input reading_done, input distance_q8, input object_near,
                    input timed_out, output ready);
endinterface

interface ura_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ura_pkg::CFG_IDX_BITS-1:0]   index;
    logic [ura_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/ura_engine.sv
// Ranging sequencer: phase state, echo timing and distance, one tick per step.
module ura_engine #(
    parameter int WIDTH_BITS = 16,
    parameter int COUNT_BITS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             echo,
    input  ura_pkg::cfg_t    cfg,
    output ura_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_SETTLE  = 3'd0,
        PH_PULSE   = 3'd1,
        PH_WAIT    = 3'd2,
        PH_MEASURE = 3'd3,
        PH_ALARM   = 3'd4,
        PH_HOLD    = 3'd5,
        PH_GAP     = 3'd6
    } phase_t;

    localparam int CW = (COUNT_BITS > 24) ? COUNT_BITS : 24;
    localparam int LW = (WIDTH_BITS > 16) ? WIDTH_BITS : 16;
    localparam int TW = (COUNT_BITS > WIDTH_BITS) ? COUNT_BITS : WIDTH_BITS;
    localparam int PW = WIDTH_BITS + 9;
    localparam int QW = PW - ura_pkg::DIST_SHIFT;
    localparam int DW = (QW > ura_pkg::DIST_BITS) ? QW : ura_pkg::DIST_BITS;
    localparam logic [CW-1:0] COUNT_MAX_W = CW'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [LW-1:0] WIDTH_MAX_L = LW'((64'd1 << WIDTH_BITS) - 64'd1);
    localparam logic [DW-1:0] DIST_MAX_W  = DW'(ura_pkg::DIST_MAX);

    phase_t                          phase_reg, phase_next;
    logic [COUNT_BITS-1:0]           tick_reg, tick_next;
    logic [WIDTH_BITS-1:0]           width_reg, width_next;
    logic [ura_pkg::DIST_BITS-1:0]   dist_reg, dist_next;
    logic                            near_reg, near_next;
    logic                            tmo_reg, tmo_next;
    ura_pkg::result_t                result_reg, result_next;

    phase_t                          ph_pre;
    logic [COUNT_BITS-1:0]           tick_pre;
    logic [WIDTH_BITS-1:0]           width_pre;
    logic                            trig, buzz, fin, fin_tmo;
    logic [WIDTH_BITS-1:0]           fin_width;
    logic [WIDTH_BITS-1:0]           lim;
    logic [LW-1:0]                   lim_l;
    logic [PW-1:0]                   prod;
    logic [DW-1:0]                   dist_w;
    logic [ura_pkg::DIST_BITS-1:0]   dist_fin;
    logic                            near_fin;

    function automatic logic expired(input logic [COUNT_BITS-1:0] t, input logic [23:0] len);
        logic [CW-1:0] tw;
        logic [CW-1:0] lw;
        tw = CW'(t);
        lw = CW'(len);
        if (lw > COUNT_MAX_W)
        begin
            lw = COUNT_MAX_W;
        end
        return tw >= lw;
    endfunction

    function automatic logic [COUNT_BITS-1:0] tick_inc(input logic [COUNT_BITS-1:0] t);
        return (t == '1) ? t : t + COUNT_BITS'(1);
    endfunction

    // effective echo limit: zero acts as one, clipped to the width range
    always_comb
    begin
        lim_l = LW'(cfg.echo_limit_ticks);
        if (lim_l == '0)
        begin
            lim_l = LW'(1);
        end
        if (lim_l > WIDTH_MAX_L)
        begin
            lim_l = WIDTH_MAX_L;
        end
        lim = lim_l[WIDTH_BITS-1:0];
    end

    always_comb
    begin
        phase_t      p;
        phase_t      nx;
        logic [23:0] len;
        logic        timed;
        p         = phase_reg;
        tick_pre  = tick_reg;
        width_pre = width_reg;
        trig      = 1'b0;
        buzz      = 1'b0;
        fin       = 1'b0;
        fin_tmo   = 1'b0;
        fin_width = width_reg;
        if (p > PH_GAP)
        begin
            p        = PH_SETTLE;
            tick_pre = '0;
        end
        // pass over timed phases already used up; wait phase ends the chain
        for (int i = 0; i < 5; i++)
        begin
            unique case (p)
                PH_SETTLE:
                begin
                    len = 24'(cfg.settle_ticks);
                    nx = PH_PULSE;
                    timed = 1'b1;
                end
                PH_PULSE:
                begin
                    len = 24'(cfg.pulse_ticks);
                    nx = PH_WAIT;
                    timed = 1'b1;
                end
                PH_ALARM:
                begin
                    len = cfg.alarm_ticks;
                    nx = PH_HOLD;
                    timed = 1'b1;
                end
                PH_HOLD:
                begin
                    len = cfg.holdoff_ticks;
                    nx = PH_GAP;
                    timed = 1'b1;
                end
                PH_GAP:
                begin
                    len = cfg.gap_ticks;
                    nx = PH_SETTLE;
                    timed = 1'b1;
                end
                default:
                begin
                    len = '0;
                    nx = p;
                    timed = 1'b0;
                end
            endcase
            if (timed && expired(tick_pre, len))
            begin
                p        = nx;
                tick_pre = '0;
            end
        end

        if (p == PH_WAIT)
        begin
            if (echo)
            begin
                p         = PH_MEASURE;
                width_pre = '0;
            end
            else
            begin
                tick_pre = tick_inc(tick_pre);
                if (TW'(tick_pre) >= TW'(lim))
                begin
                    fin       = 1'b1;
                    fin_tmo   = 1'b1;
                    fin_width = lim;
                end
            end
        end

        if (p == PH_MEASURE && !fin)
        begin
            if (echo)
            begin
                if (width_pre != '1)
                begin
                    width_pre = width_pre + WIDTH_BITS'(1);
                end
                fin       = width_pre >= lim;
                fin_tmo   = width_pre >= lim;
                fin_width = lim;
            end
            else
            begin
                fin       = 1'b1;
                fin_width = width_pre;
            end
        end
        else if (!fin && p != PH_WAIT)
        begin
            trig     = (p == PH_PULSE);
            buzz     = (p == PH_ALARM);
            tick_pre = tick_inc(tick_pre);
        end
        ph_pre = p;
    end

    always_comb
    begin
        prod   = PW'(fin_width) * PW'(ura_pkg::DIST_MUL);
        dist_w = DW'(prod[PW-1:ura_pkg::DIST_SHIFT]);
        if (dist_w > DIST_MAX_W)
        begin
            dist_w = DIST_MAX_W;
        end
        dist_fin = dist_w[ura_pkg::DIST_BITS-1:0];
        near_fin = dist_fin < cfg.near_threshold_q8;
    end

    always_comb
    begin
        phase_next = ph_pre;
        tick_next  = tick_pre;
        width_next = width_pre;
        dist_next  = dist_reg;
        near_next  = near_reg;
        tmo_next   = tmo_reg;
        if (fin)
        begin
            width_next = fin_width;
            dist_next  = dist_fin;
            near_next  = near_fin;
            tmo_next   = fin_tmo;
            phase_next = near_fin ? PH_ALARM : PH_GAP;
            tick_next  = '0;
        end
        result_next.trigger_out  = trig;
        result_next.buzzer_out   = buzz;
        result_next.reading_done = fin;
        result_next.distance_q8  = dist_next;
        result_next.object_near  = near_next;
        result_next.timed_out    = tmo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SETTLE;
            tick_reg   <= '0;
            width_reg  <= '0;
            dist_reg   <= '0;
            near_reg   <= 1'b0;
            tmo_reg    <= 1'b0;
            result_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            width_reg  <= width_next;
            dist_reg   <= dist_next;
            near_reg   <= near_next;
            tmo_reg    <= tmo_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### rtl/core/ultrasonic_range_alarm_top.sv
// Top level of the ultrasonic range alarm: handshake, registers, sequencer.
//
//  channel   dir  payload                                        beat
//  echo_ch   in   echo_level                                     one microsecond tick
//  result_ch out  trigger_out buzzer_out reading_done            one per input beat
//                 distance_q8 object_near timed_out
//  cfg_ch    in   index (3b) data (24b)                          one register write
//
// One beat per clock sustained while result_ch is ready; an echo beat passes the input register,
// then the result register of the single-pass sequencer, before its result appears.
// Reset clears phase, counters, last reading and flags; registers take their
// defaults. No clearing pass. A stalled result holds while the next beat waits in
// the input register; cfg_ch is always ready.
module ultrasonic_range_alarm_top #(
    parameter int WIDTH_BITS = 16,
    parameter int COUNT_BITS = 24
) (
    input logic         clk,
    input logic         rst_n,
    ura_in_if.sink      echo_ch,
    ura_out_if.source   result_ch,
    ura_cfg_if.sink     cfg_ch
);

    logic             in_valid_reg;
    logic             echo_reg;
    logic             out_valid_reg;
    logic             step;
    ura_pkg::cfg_t    cfg_reg;
    ura_pkg::result_t result;

    assign step          = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign echo_ch.ready = !in_valid_reg || step;
    assign cfg_ch.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (echo_ch.ready)
            begin
                in_valid_reg <= echo_ch.valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (echo_ch.ready && echo_ch.valid)
        begin
            echo_reg <= echo_ch.echo_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ura_pkg::CFG_RESET;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                ura_pkg::CFG_SETTLE:     cfg_reg.settle_ticks      <= cfg_ch.data[7:0];
                ura_pkg::CFG_PULSE:      cfg_reg.pulse_ticks       <= cfg_ch.data[7:0];
                ura_pkg::CFG_NEAR:       cfg_reg.near_threshold_q8 <= cfg_ch.data[18:0];
                ura_pkg::CFG_ALARM:      cfg_reg.alarm_ticks       <= cfg_ch.data;
                ura_pkg::CFG_HOLDOFF:    cfg_reg.holdoff_ticks     <= cfg_ch.data;
                ura_pkg::CFG_GAP:        cfg_reg.gap_ticks         <= cfg_ch.data;
                ura_pkg::CFG_ECHO_LIMIT: cfg_reg.echo_limit_ticks  <= cfg_ch.data[15:0];
                default:                 cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    ura_engine #(
        .WIDTH_BITS(WIDTH_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .echo   (echo_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.trigger_out  = result.trigger_out;
    assign result_ch.buzzer_out   = result.buzzer_out;
    assign result_ch.reading_done = result.reading_done;
    assign result_ch.distance_q8  = result.distance_q8;
    assign result_ch.object_near  = result.object_near;
    assign result_ch.timed_out    = result.timed_out;

endmodule

### rtl/core/ura_checker.sv
// Port-level checks on the result channel of the range alarm, with bind.
module ura_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          trigger_out,
    input logic                          buzzer_out,
    input logic                          reading_done,
    input logic [ura_pkg::DIST_BITS-1:0] distance_q8,
    input logic                          object_near,
    input logic                          timed_out
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({trigger_out, buzzer_out, reading_done,
                                             distance_q8, object_near, timed_out}))
        else $error("result payload changed while stalled");

    a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(trigger_out && buzzer_out))
        else $error("trigger and buzzer high in the same tick");

    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reading_done |-> !trigger_out && !buzzer_out)
        else $error("pin driven in the tick a reading finished");

endmodule

bind ultrasonic_range_alarm_top ura_checker u_ura_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .trigger_out  (result_ch.trigger_out),
    .buzzer_out   (result_ch.buzzer_out),
    .reading_done (result_ch.reading_done),
    .distance_q8  (result_ch.distance_q8),
    .object_near  (result_ch.object_near),
    .timed_out    (result_ch.timed_out)
);

### tb/tb_top.sv
// Self-checking testbench of the ultrasonic range alarm: tick predictor, scoreboard, drivers.
`timescale 1ns / 100ps

package ura_tb_pkg;
    import ura_pkg::*;

    typedef enum logic [2:0] {
        ST_SETTLE,
        ST_PULSE,
        ST_LISTEN,
        ST_MEASURE,
        ST_ALARM,
        ST_HOLD,
        ST_GAP
    } stage_e;

    class range_scoreboard;
        cfg_t                 regs;
        stage_e               stage;
        logic [23:0]          ticks;
        logic [15:0]          echo_len;
        logic [DIST_BITS-1:0] range_q8;
        logic                 near_flag;
        logic                 late_flag;
        result_t              due[$];
        int                   readings;
        int                   failures;
        int                   beats;

        function new();
            regs      = CFG_RESET;
            stage     = ST_SETTLE;
            ticks     = '0;
            echo_len  = '0;
            range_q8  = '0;
            near_flag = 1'b0;
            late_flag = 1'b0;
            readings  = 0;
            failures  = 0;
            beats     = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function logic [15:0] echo_cap();
            return (regs.echo_limit_ticks == '0) ? 16'd1 : regs.echo_limit_ticks;
        endfunction

        // walk past timed stages whose count is already used up
        function void skip_spent(inout stage_e s, inout logic [23:0] t);
            logic [23:0] span;
            stage_e      nxt;
            bit          timed;
            timed = 1'b1;
            while (timed)
            begin
                case (s)
                    ST_SETTLE:
                    begin
                        span = 24'(regs.settle_ticks);
                        nxt  = ST_PULSE;
                    end
                    ST_PULSE:
                    begin
                        span = 24'(regs.pulse_ticks);
                        nxt  = ST_LISTEN;
                    end
                    ST_ALARM:
                    begin
                        span = regs.alarm_ticks;
                        nxt  = ST_HOLD;
                    end
                    ST_HOLD:
                    begin
                        span = regs.holdoff_ticks;
                        nxt  = ST_GAP;
                    end
                    ST_GAP:
                    begin
                        span = regs.gap_ticks;
                        nxt  = ST_SETTLE;
                    end
                    default:
                    begin
                        span  = '0;
                        nxt   = s;
                        timed = 1'b0;
                    end
                endcase
                if (timed && t >= span)
                begin
                    s = nxt;
                    t = '0;
                end
                else
                begin
                    timed = 1'b0;
                end
            end
        endfunction

        function stage_e upcoming_stage();
            stage_e      s;
            logic [23:0] t;
            s = stage;
            t = ticks;
            skip_spent(s, t);
            return s;
        endfunction

        function void close_reading(logic [15:0] len, logic late);
            logic [31:0] prod;
            prod      = (32'(len) * 32'(DIST_MUL)) >> DIST_SHIFT;
            echo_len  = len;
            range_q8  = (prod > 32'(DIST_MAX)) ? DIST_MAX : prod[DIST_BITS-1:0];
            near_flag = range_q8 < regs.near_threshold_q8;
            late_flag = late;
            stage     = near_flag ? ST_ALARM : ST_GAP;
            ticks     = '0;
            readings++;
        endfunction

        function void note_echo(logic echo);
            result_t r;
            logic    done;
            r    = '0;
            done = 1'b0;
            skip_spent(stage, ticks);
            if (stage == ST_LISTEN)
            begin
                if (echo)
                begin
                    stage    = ST_MEASURE;
                    echo_len = '0;
                end
                else
                begin
                    if (ticks != '1)
                        ticks++;
                    if (ticks >= 24'(echo_cap()))
                    begin
                        close_reading(echo_cap(), 1'b1);
                        done = 1'b1;
                    end
                end
            end
            if (stage == ST_MEASURE && !done)
            begin
                if (echo)
                begin
                    if (echo_len != '1)
                        echo_len++;
                    if (echo_len >= echo_cap())
                    begin
                        close_reading(echo_cap(), 1'b1);
                        done = 1'b1;
                    end
                end
                else
                begin
                    close_reading(echo_len, 1'b0);
                    done = 1'b1;
                end
            end
            else if (!done && stage != ST_LISTEN)
            begin
                r.trigger_out = (stage == ST_PULSE);
                r.buzzer_out  = (stage == ST_ALARM);
                if (ticks != '1)
                    ticks++;
            end
            r.reading_done = done;
            r.distance_q8  = range_q8;
            r.object_near  = near_flag;
            r.timed_out    = late_flag;
            due.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            beats++;
            if (due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("beat %0d: result with nothing expected", beats);
                return;
            end
            want = due.pop_front();
            if (got.trigger_out !== want.trigger_out || got.buzzer_out !== want.buzzer_out ||
                got.reading_done !== want.reading_done ||
                got.distance_q8 !== want.distance_q8 ||
                got.object_near !== want.object_near || got.timed_out !== want.timed_out)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("beat %0d exp/got: trig %b/%b buzz %b/%b done %b/%b", beats,
                             want.trigger_out, got.trigger_out, want.buzzer_out, got.buzzer_out,
                             want.reading_done, got.reading_done);
                    $display("beat %0d exp/got: dist %0d/%0d near %b/%b timeout %b/%b", beats,
                             want.distance_q8, got.distance_q8,
                             want.object_near, got.object_near, want.timed_out, got.timed_out);
                end
            end
        endfunction
    endclass

endpackage

module tb_top;
    import ura_pkg::*;
    import ura_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic [21:0] DIRECTED_ECHO = 22'b0000001111010011001110;
    localparam logic [5:0]  LIMIT0_ECHO   = 6'b001010;

    logic clk = 1'b0;
    logic rst_n;

    ura_in_if  echo_ch ();
    ura_out_if res_ch ();
    ura_cfg_if cfg_ch ();

    range_scoreboard book;
    bit calm;
    bit hold_sink;
    bit planned;
    int noise_pct;
    int width_cap;
    int wait_left;
    int high_left;
    int seen_readings;

    ultrasonic_range_alarm_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .echo_ch   (echo_ch),
        .result_ch (res_ch),
        .cfg_ch    (cfg_ch)
    );

    always #5 clk = ~clk;

    function automatic cfg_t small_regs();
        cfg_t c;
        c.settle_ticks      = 8'($urandom_range(6));
        c.pulse_ticks       = 8'($urandom_range(6));
        c.near_threshold_q8 = 19'($urandom_range(200));
        c.alarm_ticks       = 24'($urandom_range(15));
        c.holdoff_ticks     = 24'($urandom_range(15));
        c.gap_ticks         = 24'($urandom_range(15));
        c.echo_limit_ticks  = 16'($urandom_range(40));
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_regs(input cfg_t c);
        write_reg(CFG_SETTLE, 24'(c.settle_ticks));
        write_reg(CFG_PULSE, 24'(c.pulse_ticks));
        write_reg(CFG_NEAR, 24'(c.near_threshold_q8));
        write_reg(CFG_ALARM, c.alarm_ticks);
        write_reg(CFG_HOLDOFF, c.holdoff_ticks);
        write_reg(CFG_GAP, c.gap_ticks);
        write_reg(CFG_ECHO_LIMIT, 24'(c.echo_limit_ticks));
        cfg_ch.valid <= 1'b0;
        book.regs = c;
    endtask

    task automatic send_echo(input logic lvl);
        if (!calm && $urandom_range(99) < 19)
        begin
            echo_ch.valid <= 1'b0;
            repeat ($urandom_range(2, 1))
                @(posedge clk);
        end
        echo_ch.valid      <= 1'b1;
        echo_ch.echo_level <= lvl;
        @(posedge clk);
        while (!echo_ch.ready)
            @(posedge clk);
        book.note_echo(lvl);
    endtask

    // shape a clean echo pulse for each listen window, then flip bits as noise
    task automatic next_echo(output logic lvl);
        stage_e s;
        int     lim;
        int     top;
        s   = book.upcoming_stage();
        lim = int'(book.echo_cap());
        if (book.readings != seen_readings || (s != ST_LISTEN && s != ST_MEASURE))
            planned = 1'b0;
        seen_readings = book.readings;
        if (s == ST_LISTEN && !planned)
        begin
            planned = 1'b1;
            if (lim <= 200 && $urandom_range(7) == 0)
            begin
                wait_left = lim + 1;
                high_left = 1;
            end
            else
            begin
                top       = (width_cap < lim + 2) ? width_cap : lim + 2;
                wait_left = $urandom_range((lim > 7) ? 6 : lim - 1);
                high_left = $urandom_range(top, 1);
            end
        end
        lvl = 1'b0;
        if (planned)
        begin
            if (wait_left > 0)
                wait_left--;
            else if (high_left > 0)
            begin
                lvl = 1'b1;
                high_left--;
            end
        end
        if ($urandom_range(99) < noise_pct)
            lvl = !lvl;
    endtask

    task automatic feed_echoes(input int n);
        logic lvl;
        repeat (n)
        begin
            next_echo(lvl);
            send_echo(lvl);
        end
    endtask

    task automatic quiesce();
        echo_ch.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.trigger_out  = res_ch.trigger_out;
            got.buzzer_out   = res_ch.buzzer_out;
            got.reading_done = res_ch.reading_done;
            got.distance_q8  = res_ch.distance_q8;
            got.object_near  = res_ch.object_near;
            got.timed_out    = res_ch.timed_out;
            book.check_result(got);
        end
    end

    initial
    begin : result_sink
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                res_ch.ready <= 1'b0;
                repeat (80)
                    @(posedge clk);
                hold_sink = 1'b0;
            end
            else
            begin
                res_ch.ready <= calm || ($urandom_range(99) >= 19);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((echo_ch.valid && echo_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t c;
        book                = new();
        rst_n              <= 1'b0;
        echo_ch.valid      <= 1'b0;
        echo_ch.echo_level <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        calm          = 1'b0;
        hold_sink     = 1'b0;
        planned       = 1'b0;
        noise_pct     = 0;
        width_cap     = 40;
        seen_readings = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // wait timeout, width timeout, near and far readings with zero-length stages
        c = '{settle_ticks: 8'd0, pulse_ticks: 8'd1, near_threshold_q8: 19'd10,
              alarm_ticks: 24'd0, holdoff_ticks: 24'd0, gap_ticks: 24'd0,
              echo_limit_ticks: 16'd4};
        load_regs(c);
        for (int i = 21; i >= 0; i--)
            send_echo(DIRECTED_ECHO[i]);
        quiesce();
        // zero echo limit acts as one
        c.echo_limit_ticks = '0;
        load_regs(c);
        for (int i = 5; i >= 0; i--)
            send_echo(LIMIT0_ECHO[i]);
        quiesce();

        for (int p = 0; p < 6; p++)
        begin
            load_regs(small_regs());
            calm      = (p == 2);
            noise_pct = (p % 3 == 1) ? 15 : 3;
            if (p == 4)
                hold_sink = 1'b1;
            feed_echoes(130);
            quiesce();
        end
        calm      = 1'b0;
        noise_pct = 0;

        c = '{settle_ticks: 8'd255, pulse_ticks: 8'd255, near_threshold_q8: 19'd100,
              alarm_ticks: 24'd2, holdoff_ticks: 24'd2, gap_ticks: 24'd2,
              echo_limit_ticks: 16'd30};
        load_regs(c);
        feed_echoes(560);
        quiesce();

        c = '{settle_ticks: 8'd1, pulse_ticks: 8'd1, near_threshold_q8: 19'd287740,
              alarm_ticks: '1, holdoff_ticks: 24'd1, gap_ticks: 24'd1,
              echo_limit_ticks: 16'd20};
        load_regs(c);
        feed_echoes(60);
        quiesce();

        c.alarm_ticks   = '0;
        c.holdoff_ticks = '1;
        load_regs(c);
        feed_echoes(40);
        quiesce();

        c.holdoff_ticks     = 24'd3;
        c.gap_ticks         = '1;
        c.near_threshold_q8 = '0;
        load_regs(c);
        feed_echoes(40);
        quiesce();

        c.gap_ticks        = '0;
        c.echo_limit_ticks = '1;
        width_cap          = 300;
        load_regs(c);
        feed_echoes(250);
        quiesce();

        repeat (8)
            @(posedge clk);
        if (book.failures == 0 && book.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/ura_pkg.sv
rtl/core/ura_if.sv
rtl/core/ura_engine.sv
rtl/core/ultrasonic_range_alarm_top.sv
rtl/core/ura_checker.sv
tb/tb_top.sv
